>>> src/pfpd_pkg.sv
// Shared constants, types and the arctangent table of the pose feedback controller.
`default_nettype none
package pfpd_pkg;

   localparam int CORDIC_STEPS  = 16;
   localparam int ANG_STEPS_MAX = 24;
   localparam int CORDIC_N      = (CORDIC_STEPS > ANG_STEPS_MAX) ? ANG_STEPS_MAX : CORDIC_STEPS;
   localparam int ITER_W        = $clog2(ANG_STEPS_MAX);

   localparam int CW = 34;
   localparam int ZW = 20;

   localparam int SQRT_STEPS = 32;
   localparam int SQRT_W     = $clog2(SQRT_STEPS);

   localparam logic signed [ZW-1:0] PI_Q16      = ZW'(205887);
   localparam logic signed [ZW-1:0] HALF_PI_Q16 = ZW'(102944);
   localparam logic signed [15:0]   YAW_LIMIT   = 16'sd25736;
   localparam logic signed [15:0]   TRIG_LIMIT  = 16'sd16384;
   localparam logic signed [CW-1:0] CORDIC_K_Q30 = CW'(652032874);
   localparam logic signed [CW-1:0] ONE_Q28      = CW'(268435456);

   localparam logic [1:0] KIND_VEL  = 2'd0;
   localparam logic [1:0] KIND_POSE = 2'd1;
   localparam logic [1:0] KIND_TICK = 2'd2;

   localparam logic [2:0] REG_GAIN_POS_X     = 3'd0;
   localparam logic [2:0] REG_GAIN_POS_Y     = 3'd1;
   localparam logic [2:0] REG_GAIN_HEADING   = 3'd2;
   localparam logic [2:0] REG_DAMP_SPEED     = 3'd3;
   localparam logic [2:0] REG_DAMP_TURN      = 3'd4;
   localparam logic [2:0] REG_TARGET_X       = 3'd5;
   localparam logic [2:0] REG_TARGET_Y       = 3'd6;
   localparam logic [2:0] REG_TARGET_HEADING = 3'd7;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_ctl_type;

   typedef struct packed {
      logic busy;
   } cordic_sts_type;

   function automatic logic signed [ZW-1:0] atan_q16(input logic [ITER_W-1:0] idx);
      logic signed [ZW-1:0] v;
      unique case (idx)
         5'd0:  v = ZW'(51472);
         5'd1:  v = ZW'(30386);
         5'd2:  v = ZW'(16055);
         5'd3:  v = ZW'(8150);
         5'd4:  v = ZW'(4091);
         5'd5:  v = ZW'(2047);
         5'd6:  v = ZW'(1024);
         5'd7:  v = ZW'(512);
         5'd8:  v = ZW'(256);
         5'd9:  v = ZW'(128);
         5'd10: v = ZW'(64);
         5'd11: v = ZW'(32);
         5'd12: v = ZW'(16);
         5'd13: v = ZW'(8);
         5'd14: v = ZW'(4);
         5'd15: v = ZW'(2);
         5'd16: v = ZW'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

>>> src/pose_feedback_pd_controller.sv
// Top level of the planar pose controller with PD feedback.
`default_nettype none
// A velocity request is stored without leaving the idle state. A pose request stores the
// position and derives the yaw from the quaternion: four multiplications on the shared
// multiplier and a CORDIC vectoring pass of 16 steps. A control tick sums the squared
// velocity on the shared multiplier and takes its 32-step square root, while the CORDIC
// unit forms the sine and cosine, then makes seven passes through the shared multiplier.
// The block takes no request while busy, but a finished command may wait at the output.
module pose_feedback_pd_controller
   import pfpd_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire         [1:0]  req_kind,
   input  wire signed  [15:0] req_quat_x,
   input  wire signed  [15:0] req_quat_y,
   input  wire signed  [15:0] req_quat_z,
   input  wire signed  [15:0] req_quat_w,
   input  wire signed  [31:0] req_pos_x,
   input  wire signed  [31:0] req_pos_y,
   input  wire signed  [31:0] req_vel_x,
   input  wire signed  [31:0] req_vel_y,
   input  wire signed  [31:0] req_turn_rate,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic signed [31:0] rsp_force_cmd,
   output logic signed [31:0] rsp_torque_cmd,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire         [2:0]  csr_index,
   input  wire         [31:0] csr_data
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_QWZ  = 5'd1;
   localparam logic [4:0] S_QXY  = 5'd2;
   localparam logic [4:0] S_QYY  = 5'd3;
   localparam logic [4:0] S_QZZ  = 5'd4;
   localparam logic [4:0] S_VPRE = 5'd5;
   localparam logic [4:0] S_VRUN = 5'd6;
   localparam logic [4:0] S_VXX  = 5'd7;
   localparam logic [4:0] S_VYY  = 5'd8;
   localparam logic [4:0] S_SQRT = 5'd9;
   localparam logic [4:0] S_SC   = 5'd10;
   localparam logic [4:0] S_M1   = 5'd11;
   localparam logic [4:0] S_M2   = 5'd12;
   localparam logic [4:0] S_M3   = 5'd13;
   localparam logic [4:0] S_M4   = 5'd14;
   localparam logic [4:0] S_M5   = 5'd15;
   localparam logic [4:0] S_M6   = 5'd16;
   localparam logic [4:0] S_M7   = 5'd17;
   localparam logic [4:0] S_FIN  = 5'd18;

   function automatic logic signed [15:0] trig_q14(input logic signed [CW-1:0] v,
                                                   input logic neg);
      logic signed [CW:0]    e;
      logic signed [CW-16:0] r;
      e = neg ? -{v[CW-1], v} : {v[CW-1], v};
      e = e + (CW+1)'(32768);
      r = (CW-15)'(e >>> 16);
      if (r > (CW-15)'(TRIG_LIMIT)) begin
         r = (CW-15)'(TRIG_LIMIT);
      end else if (r < -(CW-15)'(TRIG_LIMIT)) begin
         r = -(CW-15)'(TRIG_LIMIT);
      end
      return r[15:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh7FFFFFFF) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sh80000000) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic [4:0]        state_ff, state_in;
   logic [SQRT_W-1:0] cnt_ff, cnt_in;

   logic signed [15:0] gain_pos_x_ff, gain_pos_y_ff, gain_heading_ff;
   logic signed [15:0] damp_speed_ff, damp_turn_ff, target_heading_ff;
   logic signed [31:0] target_x_ff, target_y_ff;

   logic signed [31:0] held_pos_x_ff, held_pos_x_in, held_pos_y_ff, held_pos_y_in;
   logic signed [15:0] held_yaw_ff, held_yaw_in;
   logic signed [31:0] held_vel_x_ff, held_vel_x_in, held_vel_y_ff, held_vel_y_in;
   logic signed [31:0] held_turn_rate_ff, held_turn_rate_in;

   logic signed [15:0] qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in, qw_ff, qw_in;

   logic signed [63:0] acc_f_ff, acc_f_in, acc_t_ff, acc_t_in;
   logic        [63:0] acc_v_ff, acc_v_in;
   logic signed [CW-1:0] t1_ff, t1_in;
   logic [CW-1:0]      rem_ff, rem_in;
   logic [31:0]        root_ff, root_in;
   logic signed [15:0] s14_ff, s14_in, c14_ff, c14_in;
   logic               zero_ff, zero_in, neg_ff, neg_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] force_ff, force_in, torque_ff, torque_in;

   logic signed [CW-1:0]   mul_a, mul_b;
   logic signed [2*CW-1:0] prod;
   logic signed [63:0]     prod_lo;

   cordic_ctl_type       cctl;
   cordic_sts_type       csts;
   logic signed [CW-1:0] cx_start, cy_start, cx_out, cy_out;
   logic signed [ZW-1:0] cz_start, cz_out;

   logic                 req_acc;
   logic signed [CW-1:0] sy, cy;
   logic signed [ZW-1:0] yaw_a;
   logic [CW-1:0]        rem_sh, trial;
   logic signed [ZW:0]   zr;
   logic signed [ZW-3:0] yaw_r;
   logic signed [63:0]   fr, tr;

   pfpd_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .ctl     (cctl),
      .x_start (cx_start),
      .y_start (cy_start),
      .z_start (cz_start),
      .sts     (csts),
      .x_out   (cx_out),
      .y_out   (cy_out),
      .z_out   (cz_out)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_QWZ: begin mul_a = CW'(qw_ff); mul_b = CW'(qz_ff); end
         S_QXY: begin mul_a = CW'(qx_ff); mul_b = CW'(qy_ff); end
         S_QYY: begin mul_a = CW'(qy_ff); mul_b = CW'(qy_ff); end
         S_QZZ: begin mul_a = CW'(qz_ff); mul_b = CW'(qz_ff); end
         S_VXX: begin mul_a = CW'(held_vel_x_ff); mul_b = CW'(held_vel_x_ff); end
         S_VYY: begin mul_a = CW'(held_vel_y_ff); mul_b = CW'(held_vel_y_ff); end
         S_M1:  begin mul_a = CW'(gain_pos_x_ff); mul_b = CW'(c14_ff); end
         S_M2: begin
            mul_a = t1_ff;
            mul_b = CW'(target_x_ff) - CW'(held_pos_x_ff);
         end
         S_M3:  begin mul_a = CW'(gain_pos_y_ff); mul_b = CW'(s14_ff); end
         S_M4: begin
            mul_a = t1_ff;
            mul_b = CW'(target_y_ff) - CW'(held_pos_y_ff);
         end
         S_M5:  begin mul_a = CW'(damp_speed_ff); mul_b = signed'({2'b00, root_ff}); end
         S_M6: begin
            mul_a = CW'(gain_heading_ff);
            mul_b = CW'(target_heading_ff) - CW'(held_yaw_ff);
         end
         S_M7:  begin mul_a = CW'(damp_turn_ff); mul_b = CW'(held_turn_rate_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      prod    = mul_a * mul_b;
      prod_lo = prod[63:0];
   end

   always_comb begin
      state_in          = state_ff;
      cnt_in            = cnt_ff;
      held_pos_x_in     = held_pos_x_ff;
      held_pos_y_in     = held_pos_y_ff;
      held_yaw_in       = held_yaw_ff;
      held_vel_x_in     = held_vel_x_ff;
      held_vel_y_in     = held_vel_y_ff;
      held_turn_rate_in = held_turn_rate_ff;
      qx_in             = qx_ff;
      qy_in             = qy_ff;
      qz_in             = qz_ff;
      qw_in             = qw_ff;
      acc_f_in          = acc_f_ff;
      acc_t_in          = acc_t_ff;
      acc_v_in          = acc_v_ff;
      t1_in             = t1_ff;
      rem_in            = rem_ff;
      root_in           = root_ff;
      s14_in            = s14_ff;
      c14_in            = c14_ff;
      zero_in           = zero_ff;
      neg_in            = neg_ff;
      force_in          = force_ff;
      torque_in         = torque_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      cctl.start        = 1'b0;
      cctl.vectoring    = 1'b0;
      cx_start          = '0;
      cy_start          = '0;
      cz_start          = '0;

      sy     = {acc_f_ff[CW-2:0], 1'b0};
      cy     = ONE_Q28 - {acc_t_ff[CW-2:0], 1'b0};
      yaw_a  = ZW'(held_yaw_ff) <<< 3;
      rem_sh = {rem_ff[CW-3:0], acc_v_ff[63:62]};
      trial  = {root_ff, 2'b01};
      zr     = {cz_out[ZW-1], cz_out} + (ZW+1)'(4);
      yaw_r  = (ZW-2)'(zr >>> 3);
      if (yaw_r > (ZW-2)'(YAW_LIMIT)) begin
         yaw_r = (ZW-2)'(YAW_LIMIT);
      end else if (yaw_r < -(ZW-2)'(YAW_LIMIT)) begin
         yaw_r = -(ZW-2)'(YAW_LIMIT);
      end
      fr = (acc_f_ff + 64'sd2097152) >>> 22;
      tr = (acc_t_ff + 64'sd128) >>> 8;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               unique case (req_kind)
                  KIND_VEL: begin
                     held_vel_x_in     = req_vel_x;
                     held_vel_y_in     = req_vel_y;
                     held_turn_rate_in = req_turn_rate;
                  end
                  KIND_POSE: begin
                     held_pos_x_in = req_pos_x;
                     held_pos_y_in = req_pos_y;
                     qx_in         = req_quat_x;
                     qy_in         = req_quat_y;
                     qz_in         = req_quat_z;
                     qw_in         = req_quat_w;
                     state_in      = S_QWZ;
                  end
                  KIND_TICK: begin
                     cctl.start = 1'b1;
                     cx_start   = CORDIC_K_Q30;
                     if (yaw_a > HALF_PI_Q16) begin
                        cz_start = yaw_a - PI_Q16;
                        neg_in   = 1'b1;
                     end else if (yaw_a < -HALF_PI_Q16) begin
                        cz_start = yaw_a + PI_Q16;
                        neg_in   = 1'b1;
                     end else begin
                        cz_start = yaw_a;
                        neg_in   = 1'b0;
                     end
                     state_in = S_VXX;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_QWZ: begin acc_f_in = prod_lo; state_in = S_QXY; end
         S_QXY: begin acc_f_in = acc_f_ff + prod_lo; state_in = S_QYY; end
         S_QYY: begin acc_t_in = prod_lo; state_in = S_QZZ; end
         S_QZZ: begin acc_t_in = acc_t_ff + prod_lo; state_in = S_VPRE; end
         S_VPRE: begin
            cctl.start     = 1'b1;
            cctl.vectoring = 1'b1;
            zero_in        = (sy == '0) && (cy == '0);
            if (cy[CW-1]) begin
               if (!sy[CW-1]) begin
                  cx_start = sy;
                  cy_start = -cy;
                  cz_start = HALF_PI_Q16;
               end else begin
                  cx_start = -sy;
                  cy_start = cy;
                  cz_start = -HALF_PI_Q16;
               end
            end else begin
               cx_start = cy;
               cy_start = sy;
               cz_start = '0;
            end
            state_in = S_VRUN;
         end
         S_VRUN: begin
            if (!csts.busy) begin
               held_yaw_in = zero_ff ? '0 : yaw_r[15:0];
               state_in    = S_IDLE;
            end
         end
         S_VXX: begin acc_v_in = prod_lo; state_in = S_VYY; end
         S_VYY: begin
            acc_v_in = acc_v_ff + prod_lo;
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            acc_v_in = {acc_v_ff[61:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_W'(SQRT_STEPS - 1)) begin
               state_in = S_SC;
            end
         end
         S_SC: begin
            if (!csts.busy) begin
               c14_in   = trig_q14(cx_out, neg_ff);
               s14_in   = trig_q14(cy_out, neg_ff);
               state_in = S_M1;
            end
         end
         S_M1: begin t1_in = prod_lo[CW-1:0]; state_in = S_M2; end
         S_M2: begin acc_f_in = prod_lo; state_in = S_M3; end
         S_M3: begin t1_in = prod_lo[CW-1:0]; state_in = S_M4; end
         S_M4: begin acc_f_in = acc_f_ff + prod_lo; state_in = S_M5; end
         S_M5: begin acc_f_in = acc_f_ff - (prod_lo <<< 14); state_in = S_M6; end
         S_M6: begin acc_t_in = prod_lo <<< 3; state_in = S_M7; end
         S_M7: begin acc_t_in = acc_t_ff - prod_lo; state_in = S_FIN; end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               force_in     = sat32(fr);
               torque_in    = sat32(tr);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         cnt_ff            <= '0;
         rsp_valid_ff      <= 1'b0;
         gain_pos_x_ff     <= '0;
         gain_pos_y_ff     <= '0;
         gain_heading_ff   <= '0;
         damp_speed_ff     <= '0;
         damp_turn_ff      <= '0;
         target_x_ff       <= '0;
         target_y_ff       <= '0;
         target_heading_ff <= '0;
         held_pos_x_ff     <= '0;
         held_pos_y_ff     <= '0;
         held_yaw_ff       <= '0;
         held_vel_x_ff     <= '0;
         held_vel_y_ff     <= '0;
         held_turn_rate_ff <= '0;
      end else begin
         state_ff          <= state_in;
         cnt_ff            <= cnt_in;
         rsp_valid_ff      <= rsp_valid_in;
         held_pos_x_ff     <= held_pos_x_in;
         held_pos_y_ff     <= held_pos_y_in;
         held_yaw_ff       <= held_yaw_in;
         held_vel_x_ff     <= held_vel_x_in;
         held_vel_y_ff     <= held_vel_y_in;
         held_turn_rate_ff <= held_turn_rate_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_GAIN_POS_X:     gain_pos_x_ff     <= csr_data[15:0];
               REG_GAIN_POS_Y:     gain_pos_y_ff     <= csr_data[15:0];
               REG_GAIN_HEADING:   gain_heading_ff   <= csr_data[15:0];
               REG_DAMP_SPEED:     damp_speed_ff     <= csr_data[15:0];
               REG_DAMP_TURN:      damp_turn_ff      <= csr_data[15:0];
               REG_TARGET_X:       target_x_ff       <= csr_data;
               REG_TARGET_Y:       target_y_ff       <= csr_data;
               REG_TARGET_HEADING: target_heading_ff <= csr_data[15:0];
               default: begin
               end
            endcase
         end
      end
      qx_ff     <= qx_in;
      qy_ff     <= qy_in;
      qz_ff     <= qz_in;
      qw_ff     <= qw_in;
      acc_f_ff  <= acc_f_in;
      acc_t_ff  <= acc_t_in;
      acc_v_ff  <= acc_v_in;
      t1_ff     <= t1_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      s14_ff    <= s14_in;
      c14_ff    <= c14_in;
      zero_ff   <= zero_in;
      neg_ff    <= neg_in;
      force_ff  <= force_in;
      torque_ff <= torque_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_force_cmd  = force_ff;
   assign rsp_torque_cmd = torque_ff;

endmodule
`default_nettype wire

>>> src/pfpd_cordic.sv
// Iterative CORDIC unit, one micro-rotation per cycle, for vectoring and rotation.
`default_nettype none
module pfpd_cordic
   import pfpd_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   input  cordic_ctl_type       ctl,
   input  wire signed [CW-1:0]  x_start,
   input  wire signed [CW-1:0]  y_start,
   input  wire signed [ZW-1:0]  z_start,
   output cordic_sts_type       sts,
   output logic signed [CW-1:0] x_out,
   output logic signed [CW-1:0] y_out,
   output logic signed [ZW-1:0] z_out
);

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [ITER_W-1:0]    cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 vec_ff, vec_in;
   logic signed [CW-1:0] dx, dy;
   logic signed [ZW-1:0] ang;
   logic                 rot_pos;

   always_comb begin
      dx      = y_ff >>> cnt_ff;
      dy      = x_ff >>> cnt_ff;
      ang     = atan_q16(cnt_ff);
      rot_pos = vec_ff ? y_ff[CW-1] : !z_ff[ZW-1];
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      vec_in  = vec_ff;
      if (ctl.start) begin
         x_in    = x_start;
         y_in    = y_start;
         z_in    = z_start;
         cnt_in  = '0;
         busy_in = 1'b1;
         vec_in  = ctl.vectoring;
      end else if (busy_ff) begin
         if (rot_pos) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - ang;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + ang;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ITER_W'(CORDIC_N - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         vec_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         vec_ff  <= vec_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign sts.busy = busy_ff;
   assign x_out    = x_ff;
   assign y_out    = y_ff;
   assign z_out    = z_ff;

endmodule
`default_nettype wire
